>>> design/sva_pkg.sv
package sva_pkg;

    typedef enum logic [2:0] {
        CMD_NOTE_ON     = 3'd0,
        CMD_NOTE_OFF    = 3'd1,
        CMD_ALL_OFF     = 3'd2,
        CMD_SUSTAIN_ON  = 3'd3,
        CMD_SUSTAIN_OFF = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        LOP_NONE   = 3'd0,
        LOP_APPEND = 3'd1,
        LOP_REMOVE = 3'd2,
        LOP_ERASE  = 3'd3,
        LOP_CLEAR  = 3'd4
    } t_lop;

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_in;

    typedef struct packed {
        logic [3:0] voice;
        logic       action;
        logic [6:0] voice_note;
        logic [6:0] voice_velocity;
        logic       last;
    } t_out;

    localparam logic       ACT_START   = 1'b0;
    localparam logic       ACT_RELEASE = 1'b1;
    localparam logic [6:0] FULL_VEL    = 7'd127;
    localparam logic [5:0] MAX_RESULTS = 6'd48;

endpackage

>>> design/sva_list.sv
module sva_list #(
    parameter int W         = 4,
    parameter int D         = 16,
    parameter bit SEQ_INIT  = 1'b0,
    parameter int RESET_CNT = 0,
    localparam int CW = $clog2(D + 1),
    localparam int IW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sva_pkg::t_lop i_op,
    input  logic [W-1:0]  i_val,
    input  logic [CW-1:0] i_idx,
    input  logic          i_init,
    input  logic [CW-1:0] i_init_cnt,
    input  logic [IW-1:0] i_rd_idx,
    output logic [W-1:0]  o_rd_data,
    output logic [CW-1:0] o_cnt,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        L_IDLE  = 3'b001,
        L_SCAN  = 3'b010,
        L_SHIFT = 3'b100
    } t_lstate;

    t_lstate       r_state;
    logic [W-1:0]  r_a [D];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_k;
    logic [W-1:0]  r_val;
    logic [CW-1:0] k1;
    logic          more;

    assign k1        = r_k + CW'(1);
    assign more      = ({1'b0, r_k} + (CW+1)'(1)) < {1'b0, r_cnt};
    assign o_rd_data = r_a[i_rd_idx];
    assign o_cnt     = r_cnt;
    assign o_busy    = (r_state != L_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_state <= L_IDLE;
            r_cnt   <= i_rst_n ? i_init_cnt : CW'(RESET_CNT);
            if (SEQ_INIT) begin
                for (int e = 0; e < D; e++) begin
                    r_a[e] <= W'(e);
                end
            end
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    case (i_op)
                        sva_pkg::LOP_APPEND: begin
                            if (r_cnt < CW'(D)) begin
                                r_a[r_cnt[IW-1:0]] <= i_val;
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end
                        sva_pkg::LOP_REMOVE: begin
                            if (i_idx < r_cnt) begin
                                r_k     <= i_idx;
                                r_state <= L_SHIFT;
                            end
                        end
                        sva_pkg::LOP_ERASE: begin
                            r_val   <= i_val;
                            r_k     <= '0;
                            r_state <= L_SCAN;
                        end
                        sva_pkg::LOP_CLEAR: r_cnt <= '0;
                        default: ;
                    endcase
                end
                L_SCAN: begin
                    if (r_k >= r_cnt) begin
                        r_state <= L_IDLE;
                    end else if (r_a[r_k[IW-1:0]] == r_val) begin
                        r_state <= L_SHIFT;
                    end else begin
                        r_k <= k1;
                    end
                end
                L_SHIFT: begin
                    if (more) begin
                        r_a[r_k[IW-1:0]] <= r_a[k1[IW-1:0]];
                        r_k <= k1;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

endmodule

>>> design/synth_voice_allocator_unit.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data (sva_pkg::t_in)
// output    out        o_out_valid / i_out_stall o_out_data (sva_pkg::t_out)
// config    in         i_cfg_we                  i_cfg_data (active_voices)
// One event is worked by a sequencer over the list units, which search and shift
// one entry per cycle; how long an event lasts grows with the lists that it walks,
// plus any output stalls, and the input is stalled until the event ends.
// Each command beat leaves through a hold stage and an output register.
// Reset and a configuration write rebuild the lists.
// Output stalls freeze the sequencer only when a command cannot move on.
module synth_voice_allocator_unit #(
    parameter int NUM_VOICES    = 16,
    parameter int STOLEN_DEPTH  = 16,
    parameter int SUSTAIN_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sva_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sva_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [4:0]     i_cfg_data
);

    localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CWV  = $clog2(NUM_VOICES + 1);
    localparam int SIW  = (STOLEN_DEPTH > 1) ? $clog2(STOLEN_DEPTH) : 1;
    localparam int CWS  = $clog2(STOLEN_DEPTH + 1);
    localparam int UIW  = (SUSTAIN_DEPTH > 1) ? $clog2(SUSTAIN_DEPTH) : 1;
    localparam int CWU  = $clog2(SUSTAIN_DEPTH + 1);
    localparam int FREE_RST = (NUM_VOICES < 16) ? NUM_VOICES : 16;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_WAIT      = 16'h0002,
        S_EMIT      = 16'h0004,
        S_FIN       = 16'h0008,
        S_ON_SCAN   = 16'h0010,
        S_ON_ALLOC  = 16'h0020,
        S_ON_STEAL  = 16'h0040,
        S_ON_STEAL2 = 16'h0080,
        S_ON_PUT    = 16'h0100,
        S_REL       = 16'h0200,
        S_REL_SCAN  = 16'h0400,
        S_REL_FREE  = 16'h0800,
        S_REL_HAND  = 16'h1000,
        S_AO        = 16'h2000,
        S_AO_FREE   = 16'h4000,
        S_SO_NEXT   = 16'h8000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [6:0]     r_n, n_n, r_vel, n_vel, r_rn, n_rn, r_m, n_m;
    logic [VW-1:0]  r_v, n_v;
    logic [CWV-1:0] r_k, n_k;
    logic [CWU-1:0] r_j, n_j;
    logic [5:0]     r_ecnt, n_ecnt;
    logic           r_held, n_held, r_susoff, n_susoff;
    sva_pkg::t_out  r_e, n_e, r_hold, n_hold, r_out, n_out;
    logic           r_hold_v, n_hold_v, r_out_v;
    logic           out_load, out_free;

    logic [6:0]     r_notes [NUM_VOICES];
    logic           note_we;
    logic [VW-1:0]  note_idx;
    logic [6:0]     note_val;

    sva_pkg::t_lop  pl_op, fr_op, st_op, su_op;
    logic [VW-1:0]  pl_val, fr_val, pl_rd, fr_rd;
    logic [CWV-1:0] pl_idx, fr_idx, pl_cnt, fr_cnt;
    logic [6:0]     st_val, su_val, st_rd, su_rd;
    logic [CWS-1:0] st_cnt, st_last;
    logic [CWU-1:0] su_cnt;
    logic           pl_busy, fr_busy, st_busy, su_busy;
    logic [6:0]     cfg_ext, cfg_clamp;
    logic [6:0]     pv_note;

    assign cfg_ext   = 7'(i_cfg_data);
    assign cfg_clamp = (cfg_ext == 7'd0) ? 7'd1 :
                       (cfg_ext > 7'(NUM_VOICES)) ? 7'(NUM_VOICES) : cfg_ext;
    assign st_last   = st_cnt - CWS'(1);
    assign pv_note   = r_notes[pl_rd];

    sva_list #(.W(VW), .D(NUM_VOICES)) u_play (
        .i_clk, .i_rst_n, .i_op(pl_op), .i_val(pl_val), .i_idx(pl_idx),
        .i_init(i_cfg_we), .i_init_cnt('0), .i_rd_idx(r_k[VW-1:0]),
        .o_rd_data(pl_rd), .o_cnt(pl_cnt), .o_busy(pl_busy)
    );

    sva_list #(.W(VW), .D(NUM_VOICES), .SEQ_INIT(1'b1), .RESET_CNT(FREE_RST)) u_free (
        .i_clk, .i_rst_n, .i_op(fr_op), .i_val(fr_val), .i_idx(fr_idx),
        .i_init(i_cfg_we), .i_init_cnt(CWV'(cfg_clamp)), .i_rd_idx('0),
        .o_rd_data(fr_rd), .o_cnt(fr_cnt), .o_busy(fr_busy)
    );

    sva_list #(.W(7), .D(STOLEN_DEPTH)) u_stolen (
        .i_clk, .i_rst_n, .i_op(st_op), .i_val(st_val), .i_idx('0),
        .i_init(i_cfg_we), .i_init_cnt('0), .i_rd_idx(st_last[SIW-1:0]),
        .o_rd_data(st_rd), .o_cnt(st_cnt), .o_busy(st_busy)
    );

    sva_list #(.W(7), .D(SUSTAIN_DEPTH)) u_sustain (
        .i_clk, .i_rst_n, .i_op(su_op), .i_val(su_val), .i_idx('0),
        .i_init(i_cfg_we), .i_init_cnt('0), .i_rd_idx(r_j[UIW-1:0]),
        .o_rd_data(su_rd), .o_cnt(su_cnt), .o_busy(su_busy)
    );

    assign out_free    = !r_out_v || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_n = r_n;      n_vel = r_vel;
        n_rn = r_rn;        n_m = r_m;       n_v = r_v;      n_k = r_k;
        n_j = r_j;          n_ecnt = r_ecnt; n_held = r_held; n_susoff = r_susoff;
        n_e = r_e;          n_hold = r_hold; n_hold_v = r_hold_v;
        n_out = r_out;      out_load = 1'b0;
        note_we = 1'b0;     note_idx = r_v;  note_val = r_n;
        pl_op = sva_pkg::LOP_NONE; pl_val = r_v; pl_idx = r_k;
        fr_op = sva_pkg::LOP_NONE; fr_val = r_v; fr_idx = '0;
        st_op = sva_pkg::LOP_NONE; st_val = r_rn;
        su_op = sva_pkg::LOP_NONE; su_val = i_in_data.note;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n    = i_in_data.note;
                    n_vel  = i_in_data.velocity;
                    n_ecnt = '0;
                    n_k    = '0;
                    case (i_in_data.cmd)
                        sva_pkg::CMD_NOTE_ON: begin
                            su_op   = sva_pkg::LOP_ERASE;
                            n_ret   = S_ON_SCAN;
                            n_state = S_WAIT;
                        end
                        sva_pkg::CMD_NOTE_OFF: begin
                            if (r_held) begin
                                su_op   = sva_pkg::LOP_APPEND;
                                n_state = S_FIN;
                            end else begin
                                n_rn     = i_in_data.note;
                                n_susoff = 1'b0;
                                n_state  = S_REL;
                            end
                        end
                        sva_pkg::CMD_ALL_OFF: n_state = S_AO;
                        sva_pkg::CMD_SUSTAIN_ON: begin
                            n_held  = 1'b1;
                            n_state = S_FIN;
                        end
                        sva_pkg::CMD_SUSTAIN_OFF: begin
                            n_held   = 1'b0;
                            n_j      = '0;
                            n_susoff = 1'b1;
                            n_state  = S_SO_NEXT;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_WAIT: begin
                if (!(pl_busy || fr_busy || st_busy || su_busy)) begin
                    n_state = r_ret;
                end
            end
            S_EMIT: begin
                if (r_ecnt >= sva_pkg::MAX_RESULTS) begin
                    n_state = r_ret;
                end else if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out    = r_hold;
                        out_load = 1'b1;
                    end
                    n_hold   = r_e;
                    n_hold_v = 1'b1;
                    n_ecnt   = r_ecnt + 6'd1;
                    n_state  = r_ret;
                end
            end
            S_FIN: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    out_load   = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_ON_SCAN: begin
                if (r_k >= pl_cnt) begin
                    n_k     = '0;
                    n_state = S_ON_ALLOC;
                end else if (pv_note == r_n) begin
                    n_v     = pl_rd;
                    pl_op   = sva_pkg::LOP_REMOVE;
                    n_ret   = S_ON_PUT;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + CWV'(1);
                end
            end
            S_ON_ALLOC: begin
                if (fr_cnt != '0) begin
                    n_v     = fr_rd;
                    fr_op   = sva_pkg::LOP_REMOVE;
                    n_ret   = S_ON_PUT;
                    n_state = S_WAIT;
                end else if (pl_cnt != '0) begin
                    // Steal the oldest playing voice.
                    n_v     = pl_rd;
                    pl_op   = sva_pkg::LOP_REMOVE;
                    n_ret   = S_ON_STEAL;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ON_STEAL: begin
                if ({1'b0, st_cnt} >= (CWS+1)'(STOLEN_DEPTH)) begin
                    st_op   = sva_pkg::LOP_REMOVE;
                    n_ret   = S_ON_STEAL2;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_ON_STEAL2;
                end
            end
            S_ON_STEAL2: begin
                st_op   = sva_pkg::LOP_APPEND;
                st_val  = r_notes[r_v];
                n_state = S_ON_PUT;
            end
            S_ON_PUT: begin
                pl_op   = sva_pkg::LOP_APPEND;
                note_we = 1'b1;
                n_e     = '{voice: 4'(r_v), action: sva_pkg::ACT_START,
                            voice_note: r_n, voice_velocity: r_vel, last: 1'b0};
                n_ret   = S_FIN;
                n_state = S_EMIT;
            end
            S_REL: begin
                st_op   = sva_pkg::LOP_ERASE;
                n_k     = '0;
                n_ret   = S_REL_SCAN;
                n_state = S_WAIT;
            end
            S_REL_SCAN: begin
                if (r_k >= pl_cnt) begin
                    n_state = r_susoff ? S_SO_NEXT : S_FIN;
                end else if (pv_note != r_rn) begin
                    n_k = r_k + CWV'(1);
                end else begin
                    n_v = pl_rd;
                    if (st_cnt == '0) begin
                        n_e     = '{voice: 4'(pl_rd), action: sva_pkg::ACT_RELEASE,
                                    voice_note: 7'd0, voice_velocity: 7'd0, last: 1'b0};
                        n_ret   = S_REL_FREE;
                        n_state = S_EMIT;
                    end else begin
                        // Hand the voice the most recently stolen note.
                        n_m     = st_rd;
                        st_op   = sva_pkg::LOP_ERASE;
                        st_val  = st_rd;
                        pl_op   = sva_pkg::LOP_REMOVE;
                        n_ret   = S_REL_HAND;
                        n_state = S_WAIT;
                    end
                end
            end
            S_REL_FREE: begin
                fr_op   = sva_pkg::LOP_APPEND;
                pl_op   = sva_pkg::LOP_REMOVE;
                n_ret   = S_REL_SCAN;
                n_state = S_WAIT;
            end
            S_REL_HAND: begin
                pl_op    = sva_pkg::LOP_APPEND;
                note_we  = 1'b1;
                note_val = r_m;
                n_e      = '{voice: 4'(r_v), action: sva_pkg::ACT_START,
                             voice_note: r_m, voice_velocity: sva_pkg::FULL_VEL,
                             last: 1'b0};
                n_ret    = S_REL_SCAN;
                n_state  = S_EMIT;
            end
            S_AO: begin
                if (r_k >= pl_cnt) begin
                    pl_op   = sva_pkg::LOP_CLEAR;
                    st_op   = sva_pkg::LOP_CLEAR;
                    n_state = S_FIN;
                end else begin
                    n_v     = pl_rd;
                    n_e     = '{voice: 4'(pl_rd), action: sva_pkg::ACT_RELEASE,
                                voice_note: 7'd0, voice_velocity: 7'd0, last: 1'b0};
                    n_ret   = S_AO_FREE;
                    n_state = S_EMIT;
                end
            end
            S_AO_FREE: begin
                fr_op   = sva_pkg::LOP_APPEND;
                n_k     = r_k + CWV'(1);
                n_state = S_AO;
            end
            S_SO_NEXT: begin
                if (r_j >= su_cnt) begin
                    su_op   = sva_pkg::LOP_CLEAR;
                    n_state = S_FIN;
                end else begin
                    n_rn    = su_rd;
                    n_j     = r_j + CWU'(1);
                    n_state = S_REL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_held   <= 1'b0;
            r_susoff <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_ecnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_held   <= n_held;
            r_susoff <= n_susoff;
            r_hold_v <= n_hold_v;
            r_ecnt   <= n_ecnt;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_vel  <= n_vel;
        r_rn   <= n_rn;
        r_m    <= n_m;
        r_v    <= n_v;
        r_k    <= n_k;
        r_j    <= n_j;
        r_e    <= n_e;
        r_hold <= n_hold;
        r_out  <= n_out;
        if (note_we) begin
            r_notes[note_idx] <= note_val;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("command left in hold stage at end of event");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= sva_pkg::MAX_RESULTS)
        else $error("result count beyond limit");

    // A released voice joins the free list before it leaves the playing list,
    // so the total is only checked between events.
    a_voice_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (({1'b0, pl_cnt} + {1'b0, fr_cnt}) <= (CWV+1)'(NUM_VOICES)))
        else $error("playing and free voices exceed voice count");
`endif

endmodule

>>> tb/tb_synth_voice_allocator_unit.sv
`timescale 1ns / 1ps

module tb_synth_voice_allocator_unit;

    localparam int NV = 16;
    localparam int SD = 16;
    localparam int PD = 32;
    localparam int MAXC = 48;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    sva_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    sva_pkg::t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [4:0] i_cfg_data = 5'd0;

    synth_voice_allocator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Allocator mirror.
    int unsigned n_active;
    logic [3:0] age_list [NV];
    int unsigned age_cnt;
    logic [3:0] idle_list [NV];
    int unsigned idle_cnt;
    logic [6:0] note_of [NV];
    logic [6:0] steal_list [SD];
    int unsigned steal_cnt;
    logic [6:0] held_list [PD];
    int unsigned held_cnt;
    bit pedal;

    sva_pkg::t_in event_q[$];
    sva_pkg::t_out cmd_q[$];
    int emitted;
    bit failed = 1'b0;
    int unsigned gap_left = 0, burst_left = 0, stall_phase = 0;

    function automatic void rebuild_voices();
        age_cnt = 0; steal_cnt = 0; held_cnt = 0;
        for (int k = 0; k < NV; k++) begin
            note_of[k] = '0;
            idle_list[k] = k[3:0];
        end
        idle_cnt = n_active;
    endfunction

    function automatic void push_cmd(logic [3:0] v, logic act, logic [6:0] n, logic [6:0] vel);
        sva_pkg::t_out c;
        if (emitted >= MAXC) return;
        c.voice = v; c.action = act; c.voice_note = n; c.voice_velocity = vel; c.last = 1'b0;
        cmd_q = {cmd_q, c};
        emitted++;
    endfunction

    function automatic void drop_age(int unsigned i);
        for (int unsigned k = i; k + 1 < age_cnt; k++) age_list[k] = age_list[k + 1];
        age_cnt--;
    endfunction

    function automatic void drop_steal(int unsigned i);
        for (int unsigned k = i; k + 1 < steal_cnt; k++) steal_list[k] = steal_list[k + 1];
        steal_cnt--;
    endfunction

    function automatic void erase_steal(logic [6:0] n);
        for (int unsigned k = 0; k < steal_cnt; k++)
            if (steal_list[k] == n) begin
                drop_steal(k);
                return;
            end
    endfunction

    function automatic void release_note(logic [6:0] n);
        int unsigned i;
        logic [3:0] v;
        logic [6:0] m;
        i = 0;
        erase_steal(n);
        while (i < age_cnt) begin
            v = age_list[i];
            if (note_of[v] != n) begin
                i++;
                continue;
            end
            if (steal_cnt == 0) begin
                push_cmd(v, sva_pkg::ACT_RELEASE, '0, '0);
                if (idle_cnt < NV) idle_list[idle_cnt++] = v;
                drop_age(i);
            end else begin
                m = steal_list[steal_cnt - 1];
                erase_steal(m);
                drop_age(i);
                age_list[age_cnt++] = v;
                note_of[v] = m;
                push_cmd(v, sva_pkg::ACT_START, m, sva_pkg::FULL_VEL);
            end
        end
    endfunction

    function automatic void start_note(logic [6:0] n, logic [6:0] vel);
        bit found;
        logic [3:0] v;
        found = 0; v = '0;
        for (int unsigned k = 0; k < held_cnt; k++)
            if (held_list[k] == n) begin
                for (int unsigned j = k; j + 1 < held_cnt; j++) held_list[j] = held_list[j + 1];
                held_cnt--;
                break;
            end
        for (int unsigned k = 0; k < age_cnt; k++)
            if (note_of[age_list[k]] == n) begin
                v = age_list[k];
                drop_age(k);
                found = 1;
                break;
            end
        if (!found) begin
            if (idle_cnt > 0) begin
                v = idle_list[0];
                for (int unsigned k = 0; k + 1 < idle_cnt; k++) idle_list[k] = idle_list[k + 1];
                idle_cnt--;
            end else if (age_cnt > 0) begin
                v = age_list[0];
                drop_age(0);
                if (steal_cnt >= SD) drop_steal(0);
                steal_list[steal_cnt++] = note_of[v];
            end else begin
                return;
            end
        end
        if (age_cnt < NV) age_list[age_cnt++] = v;
        note_of[v] = n;
        push_cmd(v, sva_pkg::ACT_START, n, vel);
    endfunction

    function automatic void predict_event(sva_pkg::t_in e);
        emitted = 0;
        case (e.cmd)
            sva_pkg::CMD_NOTE_ON: start_note(e.note, e.velocity);
            sva_pkg::CMD_NOTE_OFF: begin
                if (pedal) begin
                    if (held_cnt < PD) held_list[held_cnt++] = e.note;
                end else begin
                    release_note(e.note);
                end
            end
            sva_pkg::CMD_ALL_OFF: begin
                for (int unsigned k = 0; k < age_cnt; k++) begin
                    push_cmd(age_list[k], sva_pkg::ACT_RELEASE, '0, '0);
                    if (idle_cnt < NV) idle_list[idle_cnt++] = age_list[k];
                end
                age_cnt = 0;
                steal_cnt = 0;
            end
            sva_pkg::CMD_SUSTAIN_ON: pedal = 1;
            sva_pkg::CMD_SUSTAIN_OFF: begin
                pedal = 0;
                for (int unsigned k = 0; k < held_cnt; k++) release_note(held_list[k]);
                held_cnt = 0;
            end
            default: ;
        endcase
        if (emitted > 0) cmd_q[$].last = 1'b1;
    endfunction

    // Driver: bursts with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_event(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (i_in_valid && !o_in_stall) event_q.delete(0);
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= event_q[0];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and output stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t unexpected command: expected none actual %p", $time,
                             o_out_data);
                    failed = 1'b1;
                end else begin
                    if (o_out_data !== cmd_q[0]) begin
                        $display("%0t mismatch: expected %p actual %p", $time, cmd_q[0],
                                 o_out_data);
                        failed = 1'b1;
                    end
                    cmd_q.delete(0);
                end
            end
            stall_phase++;
            case ((stall_phase / 200) % 3)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    function automatic sva_pkg::t_in mk(logic [2:0] c, logic [6:0] n, logic [6:0] v);
        sva_pkg::t_in e;
        e.cmd = c; e.note = n; e.velocity = v;
        return e;
    endfunction

    function automatic void add_event(sva_pkg::t_in e);
        event_q = {event_q, e};
    endfunction

    task automatic drain();
        while (event_q.size() > 0 || i_in_valid || cmd_q.size() > 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic set_voices(logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_active = (val == 0) ? 1 : (val > NV ? NV : val);
        rebuild_voices();
    endtask

    task automatic random_phase(int cnt, int note_span);
        int r;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                add_event(mk(sva_pkg::CMD_NOTE_ON, 7'($urandom_range(0, note_span)),
                             7'($urandom_range(0, 127))));
            else if (r < 80)
                add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'($urandom_range(0, note_span)),
                             7'($urandom)));
            else if (r < 85)
                add_event(mk(sva_pkg::CMD_ALL_OFF, 7'($urandom), 7'($urandom)));
            else if (r < 91)
                add_event(mk(sva_pkg::CMD_SUSTAIN_ON, 7'($urandom), 7'($urandom)));
            else if (r < 97)
                add_event(mk(sva_pkg::CMD_SUSTAIN_OFF, 7'($urandom), 7'($urandom)));
            else
                add_event(mk(3'($urandom_range(5, 7)), 7'($urandom), 7'($urandom)));
        end
        drain();
    endtask

    initial begin
        n_active = NV;
        pedal = 0;
        rebuild_voices();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, retrigger, stealing and handing back, sustain, junk codes.
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd0, 7'd0));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd127, 7'd127));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd127, 7'd64));
        add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'd0, 7'd127));
        add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'd55, 7'd0));
        add_event(mk(3'd5, 7'd127, 7'd127));
        add_event(mk(3'd7, 7'd1, 7'd1));
        add_event(mk(sva_pkg::CMD_ALL_OFF, 7'd0, 7'd0));
        drain();
        set_voices(5'd2);
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd10, 7'd1));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd11, 7'd2));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd12, 7'd3));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd13, 7'd4));
        add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'd13, 7'd0));
        add_event(mk(sva_pkg::CMD_SUSTAIN_ON, 7'd0, 7'd0));
        add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'd12, 7'd0));
        add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'd11, 7'd0));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd12, 7'd9));
        add_event(mk(sva_pkg::CMD_SUSTAIN_OFF, 7'd0, 7'd0));
        add_event(mk(sva_pkg::CMD_NOTE_ON, 7'd20, 7'd5));
        add_event(mk(sva_pkg::CMD_ALL_OFF, 7'd0, 7'd0));
        drain();

        // Zero is taken as one voice, and overlarge values saturate.
        set_voices(5'd0);
        random_phase(20, 7);
        set_voices(5'd31);
        random_phase(30, 40);
        set_voices(5'd4);
        random_phase(20, 12);
        set_voices(5'd16);
        // Many deferred releases in one pedal lift, beyond the list depth.
        for (int i = 0; i < 16; i++) add_event(mk(sva_pkg::CMD_NOTE_ON, 7'(i), 7'd100));
        add_event(mk(sva_pkg::CMD_SUSTAIN_ON, 7'd0, 7'd0));
        for (int i = 0; i < 34; i++) add_event(mk(sva_pkg::CMD_NOTE_OFF, 7'(i % 16), 7'd0));
        add_event(mk(sva_pkg::CMD_SUSTAIN_OFF, 7'd0, 7'd0));
        drain();
        random_phase(28, 127);

        if (!failed && cmd_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
